@@ rtl/u8d_pkg.sv @@
// Shared types and constants for the UTF-8 stream decoder.
package u8d_pkg;

    localparam int CP_W = 21;

    localparam logic [CP_W-1:0] REPL_CP = 21'h00FFFD;

    localparam logic [7:0] MASK_2B  = 8'hE0;
    localparam logic [7:0] LEAD_2B  = 8'hC0;
    localparam logic [7:0] MASK_3B  = 8'hF0;
    localparam logic [7:0] LEAD_3B  = 8'hE0;
    localparam logic [7:0] MASK_4B  = 8'hF8;
    localparam logic [7:0] LEAD_4B  = 8'hF0;
    localparam logic [7:0] MASK_CONT = 8'hC0;
    localparam logic [7:0] CONT_TAG  = 8'h80;

    // Results caused by one byte: leading replacement words, then an optional tail word.
    typedef struct packed {
        logic [1:0]      rep_cnt;
        logic            has_tail;
        logic [CP_W-1:0] tail_cp;
        logic            tail_repl;
        logic            tail_eot;
    } bundle_t;

endpackage

@@ rtl/u8d_decode.sv @@
// Sequence state and single-pass decode of one byte into a result bundle.
module u8d_decode (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             advance,
    input  logic [7:0]       byte_in,
    output u8d_pkg::bundle_t bundle,
    output logic             bundle_nonempty
);
    import u8d_pkg::*;

    logic [1:0]      remaining_reg, remaining_next;
    logic [1:0]      collected_reg, collected_next;
    logic [CP_W-1:0] partial_reg, partial_next;

    logic is_cont;
    logic [CP_W-1:0] shifted;

    assign is_cont = (byte_in & MASK_CONT) == CONT_TAG;
    assign shifted = {partial_reg[CP_W-7:0], byte_in[5:0]};

    // Decode the byte against the current sequence state.
    always_comb
    begin
        logic lead_path;
        lead_path      = 1'b0;
        remaining_next = remaining_reg;
        collected_next = collected_reg;
        partial_next   = partial_reg;
        bundle         = '0;

        if (remaining_reg == 2'd0)
        begin
            lead_path = 1'b1;
        end
        else if (is_cont)
        begin
            if (remaining_reg == 2'd1)
            begin
                bundle.has_tail = 1'b1;
                bundle.tail_cp  = shifted;
                remaining_next  = 2'd0;
                collected_next  = 2'd0;
                partial_next    = '0;
            end
            else
            begin
                partial_next   = shifted;
                collected_next = collected_reg + 2'd1;
                remaining_next = remaining_reg - 2'd1;
            end
        end
        else
        begin
            // Broken sequence: one replacement for the lead and each collected byte.
            bundle.rep_cnt = (collected_reg > 2'd2) ? 2'd3 : collected_reg + 2'd1;
            remaining_next = 2'd0;
            collected_next = 2'd0;
            partial_next   = '0;
            lead_path      = 1'b1;
        end

        // The byte acts as a lead.
        if (lead_path)
        begin
            if (byte_in == 8'h00)
            begin
                bundle.has_tail = 1'b1;
                bundle.tail_eot = 1'b1;
            end
            else if (!byte_in[7])
            begin
                bundle.has_tail = 1'b1;
                bundle.tail_cp  = {{(CP_W-8){1'b0}}, byte_in};
            end
            else if ((byte_in & MASK_2B) == LEAD_2B)
            begin
                partial_next   = {{(CP_W-5){1'b0}}, byte_in[4:0]};
                remaining_next = 2'd1;
                collected_next = 2'd0;
            end
            else if ((byte_in & MASK_3B) == LEAD_3B)
            begin
                partial_next   = {{(CP_W-4){1'b0}}, byte_in[3:0]};
                remaining_next = 2'd2;
                collected_next = 2'd0;
            end
            else if ((byte_in & MASK_4B) == LEAD_4B)
            begin
                partial_next   = {{(CP_W-3){1'b0}}, byte_in[2:0]};
                remaining_next = 2'd3;
                collected_next = 2'd0;
            end
            else
            begin
                bundle.has_tail  = 1'b1;
                bundle.tail_cp   = REPL_CP;
                bundle.tail_repl = 1'b1;
            end
        end
    end

    assign bundle_nonempty = bundle.has_tail || (bundle.rep_cnt != 2'd0);

    // Sequence state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            remaining_reg <= 2'd0;
            collected_reg <= 2'd0;
            partial_reg   <= '0;
        end
        else if (advance)
        begin
            remaining_reg <= remaining_next;
            collected_reg <= collected_next;
            partial_reg   <= partial_next;
        end
    end

    // A sequence never holds more than three continuation bytes in total.
    a_seq_len: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, remaining_reg} + {1'b0, collected_reg}) <= 3'd3)
        else $error("sequence length exceeds four bytes");

    // Idle state carries no collected bytes.
    a_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
        remaining_reg == 2'd0 |-> collected_reg == 2'd0)
        else $error("collected bytes while idle");

endmodule

@@ rtl/u8d_emit.sv @@
// Result register that plays out a bundle one word per output handshake.
module u8d_emit (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     load,
    input  u8d_pkg::bundle_t         bundle,
    output logic                     free,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [u8d_pkg::CP_W-1:0] code_point,
    output logic                     replaced,
    output logic                     end_of_text,
    output logic                     last
);
    import u8d_pkg::*;

    bundle_t    bun_reg;
    logic       vld_reg, vld_next;
    logic [2:0] rem_reg, rem_next;
    logic       in_reps;

    assign free = !vld_reg || (out_ready && rem_reg == 3'd1);

    // Replacement words go first, the tail word closes the bundle.
    assign in_reps     = rem_reg > {2'b0, bun_reg.has_tail};
    assign out_valid   = vld_reg;
    assign code_point  = in_reps ? REPL_CP : bun_reg.tail_cp;
    assign replaced    = in_reps ? 1'b1 : bun_reg.tail_repl;
    assign end_of_text = in_reps ? 1'b0 : bun_reg.tail_eot;
    assign last        = rem_reg == 3'd1;

    // Word count bookkeeping.
    always_comb
    begin
        vld_next = vld_reg;
        rem_next = rem_reg;
        if (load)
        begin
            vld_next = 1'b1;
            rem_next = {1'b0, bundle.rep_cnt} + {2'b0, bundle.has_tail};
        end
        else if (vld_reg && out_ready)
        begin
            if (rem_reg == 3'd1)
            begin
                vld_next = 1'b0;
            end
            rem_next = rem_reg - 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
            rem_reg <= 3'd0;
        end
        else
        begin
            vld_reg <= vld_next;
            rem_reg <= rem_next;
        end
    end

    // Bundle payload.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            bun_reg <= bundle;
        end
    end

    // A held bundle always has between one and four words left.
    a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg |-> (rem_reg != 3'd0 && rem_reg <= 3'd4))
        else $error("word count out of range");

    // A new bundle never overwrites words still to be sent.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> free)
        else $error("bundle loaded over pending words");

    // A taken word that is not the last one steps the count down by one.
    a_step: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg && out_ready && rem_reg != 3'd1 && !load)
        |=> (vld_reg && rem_reg == $past(rem_reg) - 3'd1))
        else $error("word count did not step");

endmodule

@@ rtl/utf8_stream_decoder.sv @@
// Top level of the UTF-8 stream decoder: input register, decoder and result register.
// Data path: an accepted byte is held in the input register and decoded combinationally;
// its bundle is loaded into the result register once that register is free.
// Throughput: one byte per cycle if each byte gives at most one word and out_ready is high;
// a byte of k words holds the result register for k output handshakes (k is at most four).
// Reset (rst_n low, asynchronous) empties both registers and returns the decoder to idle.
module utf8_stream_decoder (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [7:0]               in_byte,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [u8d_pkg::CP_W-1:0] code_point,
    output logic                     replaced,
    output logic                     end_of_text,
    output logic                     last
);
    import u8d_pkg::*;

    logic       byte_vld_reg, byte_vld_next;
    logic [7:0] byte_reg;
    logic       advance;
    logic       free;
    logic       nonempty;
    bundle_t    bundle;

    // A held byte moves on once the result register can take its bundle.
    assign advance  = byte_vld_reg && free;
    assign in_ready = !byte_vld_reg || free;

    always_comb
    begin
        byte_vld_next = byte_vld_reg;
        if (in_valid && in_ready)
        begin
            byte_vld_next = 1'b1;
        end
        else if (advance)
        begin
            byte_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_vld_reg <= 1'b0;
        end
        else
        begin
            byte_vld_reg <= byte_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            byte_reg <= in_byte;
        end
    end

    u8d_decode u_decode (
        .clk             (clk),
        .rst_n           (rst_n),
        .advance         (advance),
        .byte_in         (byte_reg),
        .bundle          (bundle),
        .bundle_nonempty (nonempty)
    );

    u8d_emit u_emit (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (advance && nonempty),
        .bundle      (bundle),
        .free        (free),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .code_point  (code_point),
        .replaced    (replaced),
        .end_of_text (end_of_text),
        .last        (last)
    );

endmodule

@@ dv/tb_utf8_stream_decoder.sv @@
// Self-checking testbench for the UTF-8 stream decoder: directed and random byte streams.
module tb_utf8_stream_decoder;
    import u8d_pkg::*;

    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int SETTLE_CYCLES   = 8;
    localparam int HOLD_OFF_CYCLES = 200;
    localparam int IDLE_PCT        = 32;

    // One decoded word as it should appear on the result port.
    typedef struct {
        logic [CP_W-1:0] cp;
        logic            repl;
        logic            eot;
        logic            last;
    } cp_word_t;

    logic            clk       = 1'b0;
    logic            rst_n     = 1'b0;
    logic            in_valid  = 1'b0;
    logic [7:0]      in_byte   = 8'h00;
    logic            out_ready = 1'b0;
    logic            in_ready;
    logic            out_valid;
    logic [CP_W-1:0] code_point;
    logic            replaced;
    logic            end_of_text;
    logic            last;

    // Decoder state mirrored by the testbench.
    logic [1:0]      conts_left = 2'd0;
    logic [1:0]      conts_seen = 2'd0;
    logic [CP_W-1:0] partial_cp = '0;
    cp_word_t        expected_words[$];
    int              step_words;

    int mismatches    = 0;
    int bytes_sent    = 0;
    int quiet_cycles  = 0;
    int tx_idle_pct   = IDLE_PCT;
    int rx_idle_pct   = IDLE_PCT;
    int hold_off_left = 0;

    utf8_stream_decoder dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_byte     (in_byte),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .code_point  (code_point),
        .replaced    (replaced),
        .end_of_text (end_of_text),
        .last        (last)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Decoder prediction
    // ------------------------------------------------------------------

    task automatic push_word(input logic [CP_W-1:0] cp, input logic repl, input logic eot);
        cp_word_t w;
        w.cp   = cp;
        w.repl = repl;
        w.eot  = eot;
        w.last = 1'b0;
        expected_words.push_back(w);
        step_words++;
    endtask

    task automatic clear_decoder();
        conts_left = 2'd0;
        conts_seen = 2'd0;
        partial_cp = '0;
    endtask

    // A byte seen while idle: ASCII, end of text, the start of a longer
    // character, or an invalid lead.
    task automatic start_char(input logic [7:0] b);
        if (b == 8'h00)
        begin
            push_word('0, 1'b0, 1'b1);
            clear_decoder();
        end
        else if (b[7] == 1'b0)
            push_word(CP_W'(b), 1'b0, 1'b0);
        else if ((b & MASK_2B) == LEAD_2B)
        begin
            partial_cp = CP_W'(b[4:0]);
            conts_left = 2'd1;
            conts_seen = 2'd0;
        end
        else if ((b & MASK_3B) == LEAD_3B)
        begin
            partial_cp = CP_W'(b[3:0]);
            conts_left = 2'd2;
            conts_seen = 2'd0;
        end
        else if ((b & MASK_4B) == LEAD_4B)
        begin
            partial_cp = CP_W'(b[2:0]);
            conts_left = 2'd3;
            conts_seen = 2'd0;
        end
        else
            push_word(REPL_CP, 1'b1, 1'b0);
    endtask

    task automatic decode_byte(input logic [7:0] b);
        cp_word_t tail;
        step_words = 0;
        if (conts_left == 2'd0)
            start_char(b);
        else if ((b & MASK_CONT) == CONT_TAG)
        begin
            partial_cp = {partial_cp[CP_W-7:0], b[5:0]};
            conts_seen = conts_seen + 2'd1;
            conts_left = conts_left - 2'd1;
            if (conts_left == 2'd0)
            begin
                push_word(partial_cp, 1'b0, 1'b0);
                clear_decoder();
            end
        end
        else
        begin
            // Broken sequence: one replacement for the lead and one per
            // continuation already taken, then the byte starts over as a lead.
            push_word(REPL_CP, 1'b1, 1'b0);
            repeat ((conts_seen > 2'd2) ? 2 : int'(conts_seen))
                push_word(REPL_CP, 1'b1, 1'b0);
            clear_decoder();
            start_char(b);
        end
        if (step_words > 0)
        begin
            tail = expected_words.pop_back();
            tail.last = 1'b1;
            expected_words.push_back(tail);
        end
    endtask

    // ------------------------------------------------------------------
    // Checking, receiver and watchdog
    // ------------------------------------------------------------------

    task automatic check_field(input string name, input logic [CP_W-1:0] want,
                               input logic [CP_W-1:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    // Compare each accepted word with the oldest prediction, then predict
    // the words of any byte accepted at this edge.
    always @(posedge clk)
    begin : check_words
        cp_word_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (expected_words.size() == 0)
                begin
                    $display("%0t: unexpected word, expected none, actual cp=%0h repl=%b eot=%b last=%b",
                             $time, code_point, replaced, end_of_text, last);
                    mismatches++;
                end
                else
                begin
                    want = expected_words.pop_front();
                    check_field("code_point", want.cp, code_point);
                    check_field("replaced", CP_W'(want.repl), CP_W'(replaced));
                    check_field("end_of_text", CP_W'(want.eot), CP_W'(end_of_text));
                    check_field("last", CP_W'(want.last), CP_W'(last));
                end
            end
            if (in_valid && in_ready)
                decode_byte(in_byte);
        end
    end

    // Receiver: random stalls, or a counted hold-off when one is requested.
    always @(posedge clk)
    begin
        if (hold_off_left > 0)
        begin
            out_ready <= 1'b0;
            hold_off_left <= hold_off_left - 1;
        end
        else
            out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // End the run if nothing moves on either side for too long.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    // Offer one byte, with random idle cycles ahead of it, and wait until it is taken.
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_byte  <= b;
        do
            @(posedge clk);
        while (!in_ready);
        bytes_sent++;
    endtask

    // Stop offering and wait until every predicted word has come out.
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [7:0] random_lead(input int len);
        case (len)
            1:       return 8'($urandom_range(1, 127));
            2:       return LEAD_2B | 8'($urandom_range(0, 31));
            3:       return LEAD_3B | 8'($urandom_range(0, 15));
            default: return LEAD_4B | 8'($urandom_range(0, 7));
        endcase
    endfunction

    function automatic logic [7:0] random_cont();
        return CONT_TAG | 8'($urandom_range(0, 63));
    endfunction

    // Mostly well-formed characters with random payload; the rest is end of
    // text, raw noise and sequences cut short by a foreign byte.
    task automatic send_random_sequence();
        int         pick;
        int         len;
        int         keep;
        logic [7:0] b;
        pick = $urandom_range(99);
        if (pick < 60)
        begin
            len = $urandom_range(1, 4);
            send_byte(random_lead(len));
            repeat (len - 1) send_byte(random_cont());
        end
        else if (pick < 68)
            send_byte(8'h00);
        else if (pick < 82)
            send_byte(8'($urandom));
        else
        begin
            len  = $urandom_range(2, 4);
            keep = $urandom_range(0, len - 2);
            send_byte(random_lead(len));
            repeat (keep) send_byte(random_cont());
            do
                b = 8'($urandom);
            while ((b & MASK_CONT) == CONT_TAG);
            send_byte(b);
        end
    endtask

    // Field extremes, every sequence length and each malformed case.
    task automatic test_directed_cases();
        logic [7:0] seq[$];
        seq = '{8'h00, 8'h41, 8'h7F, 8'h80, 8'hBF, 8'hF8, 8'hFF,
                8'hE2, 8'h82, 8'hAC,
                8'hF7, 8'hBF, 8'hBF, 8'hBF,
                8'hC3, 8'h41,
                8'hE2, 8'h82, 8'h00,
                8'hF0, 8'h9F, 8'h98, 8'hC5, 8'h80,
                8'hF0, 8'h9F, 8'h98, 8'hFF};
        foreach (seq[i])
            send_byte(seq[i]);
    endtask

    // A sequence left open while the sender pauses, then completed or cut off.
    task automatic test_truncated_stream();
        send_byte(8'hE2);
        send_byte(8'h82);
        wait_drained();
        send_byte(8'hAC);
        send_byte(8'hF0);
        send_byte(8'h9F);
        wait_drained();
        send_byte(8'h00);
    endtask

    // The receiver holds off while bytes keep coming, so the input stalls.
    task automatic test_output_backpressure();
        int target;
        target = bytes_sent + 40;
        tx_idle_pct = 0;
        hold_off_left = HOLD_OFF_CYCLES;
        while (bytes_sent < target)
            send_random_sequence();
        tx_idle_pct = IDLE_PCT;
    endtask

    task automatic test_random_stream();
        int target;
        target = bytes_sent + 250;
        while (bytes_sent < target)
            send_random_sequence();
    endtask

    // Full rate on both sides with no idle cycles at all.
    task automatic test_back_to_back();
        int target;
        target = bytes_sent + 60;
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        while (bytes_sent < target)
            send_random_sequence();
        tx_idle_pct = IDLE_PCT;
        rx_idle_pct = IDLE_PCT;
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_cases();
        test_truncated_stream();
        test_output_backpressure();
        test_random_stream();
        test_back_to_back();
        wait_drained();
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/u8d_pkg.sv
rtl/u8d_decode.sv
rtl/u8d_emit.sv
rtl/utf8_stream_decoder.sv
dv/tb_utf8_stream_decoder.sv
